@@ hw/rtl/pmid_pkg.sv @@
// ----------------------------------------------------------------------------
// pmid_pkg: shared constants and types for the minimum-image distance block
// Holds the fixed-point widths, register indexes and the row types that move
// through the divider cells and the square-root cells.
// ----------------------------------------------------------------------------
package pmid_pkg;

  // number format of the coordinates
  localparam int FRAC_BITS  = 12;
  localparam int COORD_BITS = 24;

  // derived widths
  localparam int NUM_AXES  = 3;
  localparam int BOX_BITS  = COORD_BITS - 1;
  localparam int VEC_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS  = COORD_BITS;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int SUM_BITS  = 2 * MAG_BITS + 2;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 1;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((2 * NUM_AXES * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((NUM_AXES * VEC_BITS + ROOT_BITS + 7) / 8) * 8;

  // pipeline depth: difference, divider cells, fold, square, sum, root cells
  localparam int NUM_STAGES = 1 + MAG_BITS + 3 + ROOT_BITS;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Z = 2'd2;

  // box edge after reset is one unit
  localparam logic [BOX_BITS-1:0] BOX_RESET = BOX_BITS'(1) << FRAC_BITS;

  typedef logic [NUM_AXES-1:0][BOX_BITS-1:0] box_vec_t;

  // one row of the divider chain
  typedef struct packed {
    logic                               op;
    logic [NUM_AXES-1:0]                neg;
    logic [NUM_AXES-1:0][MAG_BITS-1:0]  mag;
    logic [NUM_AXES-1:0][BOX_BITS-1:0]  rem;
  } div_row_t;

  // one row of the square-root chain
  typedef struct packed {
    logic [NUM_AXES-1:0][VEC_BITS-1:0]  vec;
    logic [SUM_BITS-1:0]                rad;
    logic [REM_BITS-1:0]                rem;
    logic [ROOT_BITS-1:0]               root;
  } root_row_t;

endpackage

@@ hw/rtl/pmid_div_cell.sv @@
// ----------------------------------------------------------------------------
// pmid_div_cell: one restoring-division step for all three axes
// Shifts one magnitude bit into each partial remainder and subtracts the box
// edge when it fits; the row is then registered for the next cell.
// ----------------------------------------------------------------------------
module pmid_div_cell (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  pmid_pkg::div_row_t              row_i,
  input  logic [pmid_pkg::NUM_AXES-1:0]   bit_i,
  input  pmid_pkg::box_vec_t              box_i,
  output pmid_pkg::div_row_t              row_o
);
  import pmid_pkg::*;

  div_row_t                           row_d, row_q;
  logic [NUM_AXES-1:0][MAG_BITS-1:0]  shifted;

  // trial subtract per axis
  always_comb begin
    row_d = row_i;
    for (int a = 0; a < NUM_AXES; a++) begin
      shifted[a] = {row_i.rem[a], bit_i[a]};
      if (shifted[a] >= MAG_BITS'(box_i[a])) begin
        row_d.rem[a] = BOX_BITS'(shifted[a] - MAG_BITS'(box_i[a]));
      end else begin
        row_d.rem[a] = BOX_BITS'(shifted[a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

@@ hw/rtl/pmid_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// pmid_sqrt_cell: one digit step of the integer square root
// Brings down two radicand bits, tries the next root bit and keeps the
// remainder; the vector components ride along unchanged.
// ----------------------------------------------------------------------------
module pmid_sqrt_cell (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  pmid_pkg::root_row_t  row_i,
  output pmid_pkg::root_row_t  row_o
);
  import pmid_pkg::*;

  root_row_t              row_d, row_q;
  logic [REM_BITS+1:0]    trial;
  logic [REM_BITS+1:0]    test;

  // compare remainder with 4*root+1
  always_comb begin
    row_d     = row_i;
    trial     = {row_i.rem, row_i.rad[SUM_BITS-1 -: 2]};
    test      = (REM_BITS+2)'({row_i.root, 2'b01});
    row_d.rad = row_i.rad << 2;
    if (trial >= test) begin
      row_d.rem  = REM_BITS'(trial - test);
      row_d.root = {row_i.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      row_d.rem  = REM_BITS'(trial);
      row_d.root = {row_i.root[ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

@@ hw/rtl/periodic_min_image_distance.sv @@
// ----------------------------------------------------------------------------
// periodic_min_image_distance: minimum-image vector and distance in 3D
// Takes one pair of points per clock cycle while the output is not stalled and returns
// the vector from p to q, wrapped into the periodic box when op is 0, together
// with its floored Euclidean length. The pipeline is one difference stage, a row
// of 24 divider cells that finds the remainder against each box edge, fold,
// square and sum stages, and a row of 25 square-root cells. Every stage holds
// on its own, so input keeps flowing into empty stages while a result waits.
// ----------------------------------------------------------------------------
module periodic_min_image_distance (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [pmid_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [pmid_pkg::BOX_BITS-1:0]          cfg_data_i,
  // input beats
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // p_x, p_y, p_z, q_x, q_y, q_z
  input  logic [pmid_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
  // op
  input  logic                                   s_axis_tuser,
  // result beats
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // vec_x, vec_y, vec_z, dist_res, zero pad
  output logic [pmid_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);
  import pmid_pkg::*;

  localparam int FOLD_ST = MAG_BITS + 1;
  localparam int SQ_ST   = MAG_BITS + 2;
  localparam int SUM_ST  = MAG_BITS + 3;

  box_vec_t                            box_q;
  logic [NUM_STAGES-1:0]               vld_q, vld_d, en;

  div_row_t                            diff_d;
  div_row_t                            div_row [MAG_BITS+1];

  logic                                fold_op_q;
  logic [NUM_AXES-1:0][VEC_BITS-1:0]   fold_vec_d, fold_vec_q;
  logic [NUM_AXES-1:0][MAG_BITS-1:0]   fold_mag_d, fold_mag_q;

  logic [NUM_AXES-1:0][VEC_BITS-1:0]   sq_vec_q;
  logic [NUM_AXES-1:0][SQ_BITS-1:0]    sq_q;

  root_row_t                           sum_d;
  root_row_t                           rt_row [ROOT_BITS+1];

  logic [NUM_AXES-1:0][VEC_BITS-1:0]   p_ext, q_ext, dvec;

  // box edge registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= {NUM_AXES{BOX_RESET}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BOX_X: box_q[0] <= cfg_data_i;
        CFG_BOX_Y: box_q[1] <= cfg_data_i;
        CFG_BOX_Z: box_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-stage hold: a stage loads when empty or when its successor moves
  assign en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_vld
    assign vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];

  // difference q - p with sign and magnitude
  always_comb begin
    diff_d.op = s_axis_tuser;
    for (int a = 0; a < NUM_AXES; a++) begin
      p_ext[a] = VEC_BITS'($signed(s_axis_tdata[a*COORD_BITS +: COORD_BITS]));
      q_ext[a] = VEC_BITS'($signed(s_axis_tdata[(a+NUM_AXES)*COORD_BITS +: COORD_BITS]));
      dvec[a]  = q_ext[a] - p_ext[a];
      diff_d.neg[a] = dvec[a][VEC_BITS-1];
      diff_d.mag[a] = dvec[a][VEC_BITS-1] ? MAG_BITS'(VEC_BITS'(0) - dvec[a])
                                          : MAG_BITS'(dvec[a]);
      diff_d.rem[a] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      div_row[0] <= diff_d;
    end
  end

  // divider row, one quotient bit per cell, most significant first
  for (genvar k = 0; k < MAG_BITS; k++) begin : g_div
    logic [NUM_AXES-1:0] bits;
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_bit
      assign bits[a] = div_row[k].mag[a][MAG_BITS-1-k];
    end
    pmid_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en[k+1]),
      .row_i (div_row[k]),
      .bit_i (bits),
      .box_i (box_q),
      .row_o (div_row[k+1])
    );
  end

  // fold remainder into the nearest image, rounding halves away from zero
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic s;
      s = div_row[MAG_BITS].neg[a];
      if (div_row[MAG_BITS].op || (box_q[a] == '0)) begin
        fold_mag_d[a] = div_row[MAG_BITS].mag[a];
      end else if ({div_row[MAG_BITS].rem[a], 1'b0} >= {1'b0, box_q[a]}) begin
        fold_mag_d[a] = MAG_BITS'(box_q[a] - div_row[MAG_BITS].rem[a]);
        s = ~s;
      end else begin
        fold_mag_d[a] = MAG_BITS'(div_row[MAG_BITS].rem[a]);
      end
      fold_vec_d[a] = s ? VEC_BITS'(0) - VEC_BITS'(fold_mag_d[a])
                        : VEC_BITS'(fold_mag_d[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[FOLD_ST]) begin
      fold_op_q  <= div_row[MAG_BITS].op;
      fold_vec_q <= fold_vec_d;
      fold_mag_q <= fold_mag_d;
    end
  end

  // squares, one multiplier per axis
  always_ff @(posedge clk_i) begin
    if (en[SQ_ST]) begin
      sq_vec_q <= fold_vec_q;
      for (int a = 0; a < NUM_AXES; a++) begin
        sq_q[a] <= fold_mag_q[a] * fold_mag_q[a];
      end
    end
  end

  // sum of squares seeds the root row
  always_comb begin
    sum_d.vec  = sq_vec_q;
    sum_d.rad  = SUM_BITS'(sq_q[0]) + SUM_BITS'(sq_q[1]) + SUM_BITS'(sq_q[2]);
    sum_d.rem  = '0;
    sum_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[SUM_ST]) begin
      rt_row[0] <= sum_d;
    end
  end

  // square-root row, one root bit per cell
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    pmid_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en[SUM_ST+1+k]),
      .row_i (rt_row[k]),
      .row_o (rt_row[k+1])
    );
  end

  // result beat
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];
  assign m_axis_tdata  = OUT_DATA_BITS'({rt_row[ROOT_BITS].root,
                                         rt_row[ROOT_BITS].vec[2],
                                         rt_row[ROOT_BITS].vec[1],
                                         rt_row[ROOT_BITS].vec[0]});

`ifndef SYNTHESIS
  // an empty output stage lets every stage load
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NUM_STAGES-1] |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // divider remainders stay below the box edge
  a_rem_below_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[MAG_BITS] |->
      ((box_q[0] == '0) || (div_row[MAG_BITS].rem[0] < box_q[0])) &&
      ((box_q[1] == '0) || (div_row[MAG_BITS].rem[1] < box_q[1])) &&
      ((box_q[2] == '0) || (div_row[MAG_BITS].rem[2] < box_q[2])))
    else $error("divider remainder not below box edge");

  // wrapped x component lies within half a box
  a_fold_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[FOLD_ST] && !fold_op_q && (box_q[0] != '0)) |->
      ({fold_mag_q[0], 1'b0} <= {2'b00, box_q[0]}))
    else $error("wrapped x component outside half box");
`endif

endmodule
